// ===== design/tte_pkg.sv =====
// ----------------------------------------------------------------------------
// Text terminal character engine package
// Shared constants and types for the terminal engine and its escape parser.
// ----------------------------------------------------------------------------
package tte_pkg;

	localparam int unsigned MAX_COLS_DEF  = 128;
	localparam int unsigned MAX_ROWS_DEF  = 64;
	localparam int unsigned ESC_LIMIT_DEF = 10;

	localparam int unsigned NUM_W = 27;
	localparam logic [NUM_W-1:0] NUM_SAT = {NUM_W{1'b1}};

	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_FF    = 8'd12;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_SGR   = 8'h6D;
	localparam logic [6:0] CH_SPACE = 7'd32;

	localparam logic [3:0] FG_RESET = 4'd7;
	localparam logic [3:0] BG_RESET = 4'd0;

	localparam logic [NUM_W-1:0] SGR_RESET  = 27'd0;
	localparam logic [NUM_W-1:0] SGR_FG_LO  = 27'd30;
	localparam logic [NUM_W-1:0] SGR_FG_HI  = 27'd37;
	localparam logic [NUM_W-1:0] SGR_FG_DEF = 27'd39;
	localparam logic [NUM_W-1:0] SGR_BG_LO  = 27'd40;
	localparam logic [NUM_W-1:0] SGR_BG_HI  = 27'd47;
	localparam logic [NUM_W-1:0] SGR_BG_DEF = 27'd49;

	localparam logic [7:0] COLS_RESET = 8'd80;
	localparam logic [6:0] ROWS_RESET = 7'd25;

	// Request from the sequencer to the escape parser.
	typedef struct packed {
		logic       start;
		logic       step;
		logic [7:0] ch;
	} esc_req_t;

	typedef struct packed {
		logic       active;
		logic [3:0] fg;
		logic [3:0] bg;
	} esc_stat_t;

endpackage

// ===== design/tte_mem.sv =====
// ----------------------------------------------------------------------------
// Screen store
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module tte_mem #(
	parameter int unsigned DEPTH = tte_pkg::MAX_COLS_DEF * tte_pkg::MAX_ROWS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [6:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [6:0]    rdata
);

	logic [6:0] mem [DEPTH];
	logic [6:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_q <= mem[raddr];
	end

	assign rdata = rd_data_q;

endmodule

// ===== design/tte_esc.sv =====
// ----------------------------------------------------------------------------
// Escape sequence parser
// Tracks ESC [ sequences and applies SGR colour selection.
// ----------------------------------------------------------------------------
module tte_esc #(
	parameter int unsigned ESC_LIMIT = tte_pkg::ESC_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tte_pkg::esc_req_t  req,
	output tte_pkg::esc_stat_t stat
);

	localparam int unsigned LW = $clog2(ESC_LIMIT + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_PARAM,
		PH_SECOND
	} phase_t;

	phase_t                     phase_q, phase_n;
	logic [LW-1:0]              len_q, len_n;
	logic [tte_pkg::NUM_W-1:0]  num_q, num_n;
	logic [3:0]                 fg_q, fg_n, bg_q, bg_n;
	logic                       done;
	logic                       digit;
	logic                       apply;
	logic [tte_pkg::NUM_W+3:0]  num_x10;
	logic [tte_pkg::NUM_W-1:0]  num_sub;

	assign digit   = req.ch inside {[8'h30:8'h39]};
	assign num_x10 = ({4'b0, num_q} << 3) + ({4'b0, num_q} << 1)
		+ (tte_pkg::NUM_W + 4)'(req.ch[3:0]);

	always_comb begin
		phase_n = phase_q;
		len_n   = len_q;
		num_n   = num_q;
		fg_n    = fg_q;
		bg_n    = bg_q;
		done    = 1'b0;
		apply   = 1'b0;
		num_sub = '0;
		if (req.start) begin
			phase_n = PH_START;
			len_n   = LW'(1);
			num_n   = '0;
		end else if (req.step) begin
			len_n = len_q + LW'(1);
			case (phase_q)
				PH_START: begin
					if (req.ch == tte_pkg::CH_LBRK) begin
						phase_n = PH_PARAM;
						num_n   = '0;
					end else begin
						done = 1'b1;
					end
				end
				PH_PARAM: begin
					if (digit) begin
						if (num_x10 > (tte_pkg::NUM_W + 4)'(tte_pkg::NUM_SAT)) begin
							num_n = tte_pkg::NUM_SAT;
						end else begin
							num_n = tte_pkg::NUM_W'(num_x10);
						end
					end else if (req.ch == tte_pkg::CH_SEMI) begin
						phase_n = PH_SECOND;
					end else begin
						apply = (req.ch == tte_pkg::CH_SGR);
						done  = 1'b1;
					end
				end
				PH_SECOND: begin
					if (!digit) begin
						apply = (req.ch == tte_pkg::CH_SGR);
						done  = 1'b1;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (!done && len_n >= LW'(ESC_LIMIT)) begin
				done = 1'b1;
			end
			if (apply) begin
				if (num_q == tte_pkg::SGR_RESET) begin
					fg_n = tte_pkg::FG_RESET;
					bg_n = tte_pkg::BG_RESET;
				end else if (num_q >= tte_pkg::SGR_FG_LO && num_q <= tte_pkg::SGR_FG_HI) begin
					num_sub = num_q - tte_pkg::SGR_FG_LO;
					fg_n    = num_sub[3:0];
				end else if (num_q == tte_pkg::SGR_FG_DEF) begin
					fg_n = tte_pkg::FG_RESET;
				end else if (num_q >= tte_pkg::SGR_BG_LO && num_q <= tte_pkg::SGR_BG_HI) begin
					num_sub = num_q - tte_pkg::SGR_BG_LO;
					bg_n    = num_sub[3:0];
				end else if (num_q == tte_pkg::SGR_BG_DEF) begin
					bg_n = tte_pkg::BG_RESET;
				end
			end
			if (done) begin
				phase_n = PH_IDLE;
				len_n   = '0;
				num_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			len_q   <= '0;
			num_q   <= '0;
			fg_q    <= tte_pkg::FG_RESET;
			bg_q    <= tte_pkg::BG_RESET;
		end else begin
			phase_q <= phase_n;
			len_q   <= len_n;
			num_q   <= num_n;
			fg_q    <= fg_n;
			bg_q    <= bg_n;
		end
	end

	assign stat.active = (phase_q != PH_IDLE);
	assign stat.fg     = fg_q;
	assign stat.bg     = bg_q;

endmodule

// ===== design/text_terminal_char_engine_top.sv =====
// ----------------------------------------------------------------------------
// Text terminal character engine
// Flow: an item is accepted in IDLE and its result is registered in OUT; a cell
//   read passes through RD first, carriage return and tab blank cells in FILL,
//   a scroll copies rows in SCROLL and a form feed blanks the store in CLEAR.
// Throughput: one item in flight at a time; the next item is taken only once the
//   last result is registered, later while a result waits for the receiver.
// Reset: a clearing pass blanks the store while no item is accepted;
//   configuration writes are still taken.
// ----------------------------------------------------------------------------
module text_terminal_char_engine_top #(
	parameter int unsigned MAX_COLS  = tte_pkg::MAX_COLS_DEF,
	parameter int unsigned MAX_ROWS  = tte_pkg::MAX_ROWS_DEF,
	parameter int unsigned ESC_LIMIT = tte_pkg::ESC_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // char_in[7:0], read_row[13:8], read_col[20:14]
	input  logic [0:0]  s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// cursor_row[5:0], cursor_col[12:6], fg_index[16:13], bg_index[20:17],
	// in_escape[21], scrolled[22], cleared[23], cell_char[30:24]
	output logic [31:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned SW    = AW + 1;
	localparam int unsigned CW    = $clog2(MAX_COLS);
	localparam int unsigned CW1   = $clog2(MAX_COLS + 1);
	localparam int unsigned RW    = $clog2(MAX_ROWS);
	localparam int unsigned RH1   = $clog2(MAX_ROWS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_SCROLL,
		ST_RD,
		ST_OUT
	} state_t;

	state_t        state_q;
	logic [7:0]    columns_q;
	logic [6:0]    rows_q;
	logic [RW-1:0] cur_row_q;
	logic [CW-1:0] cur_col_q;
	logic [SW-1:0] sc_q;
	logic          clr_to_out_q;
	logic [AW-1:0] fill_ptr_q;
	logic [CW1-1:0] fill_cnt_q;
	logic          scroll_pend_q;
	logic          scrolled_q, cleared_q, rd_ok_q;
	logic [6:0]    cell_q;
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;
	logic          v_s1, copy_s1;
	logic [AW-1:0] addr_s1;

	tte_pkg::esc_req_t  esc_req;
	tte_pkg::esc_stat_t esc_stat;

	logic          acc, cfg_wr;
	logic          mode;
	logic [7:0]    ch;
	logic [5:0]    rrow;
	logic [6:0]    rcol;
	logic          put, is_ff, is_ctl;
	logic [CW1-1:0] w;
	logic [RH1-1:0] h;
	logic [SW-1:0] h_tot, h_copy;
	logic [RH1-1:0] nl;
	logic [CW1-1:0] nc, f_col, f_cnt, tab_end;
	logic          sw_en, scroll;
	logic [CW-1:0] s_col;
	logic [6:0]    s_dat;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [6:0]    wdata, rdata;

	function automatic logic [AW-1:0] cell_addr(input logic [7:0] r, input logic [8:0] c);
		cell_addr = AW'(AW'(r) * AW'(MAX_COLS)) + AW'(c);
	endfunction

	assign acc    = s_tvalid && s_tready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign mode   = s_tuser[0];
	assign ch     = s_tdata[7:0];
	assign rrow   = s_tdata[13:8];
	assign rcol   = s_tdata[20:14];
	assign put    = !mode && !ch[7];
	assign is_ff  = put && !esc_stat.active && ch == tte_pkg::CH_FF;
	assign is_ctl = put && !esc_stat.active && ch != tte_pkg::CH_FF && ch != tte_pkg::CH_ESC;

	assign esc_req.start = acc && put && !esc_stat.active && ch == tte_pkg::CH_ESC;
	assign esc_req.step  = acc && put && esc_stat.active;
	assign esc_req.ch    = ch;

	tte_esc #(
		.ESC_LIMIT (ESC_LIMIT)
	) u_esc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (esc_req),
		.stat   (esc_stat)
	);

	// Clamped geometry in use.
	always_comb begin
		if (columns_q == 8'd0) begin
			w = CW1'(1);
		end else if ({1'b0, columns_q} > 9'(MAX_COLS)) begin
			w = CW1'(MAX_COLS);
		end else begin
			w = CW1'(columns_q);
		end
		if (rows_q == 7'd0) begin
			h = RH1'(1);
		end else if ({1'b0, rows_q} > 8'(MAX_ROWS)) begin
			h = RH1'(MAX_ROWS);
		end else begin
			h = RH1'(rows_q);
		end
		h_tot  = SW'(SW'(h) * SW'(MAX_COLS));
		h_copy = h_tot - SW'(MAX_COLS);
	end

	// Cursor movement and the cells a control or printable byte touches.
	always_comb begin
		nl      = RH1'(cur_row_q);
		nc      = CW1'(cur_col_q);
		f_col   = '0;
		f_cnt   = '0;
		sw_en   = 1'b0;
		s_col   = cur_col_q;
		s_dat   = tte_pkg::CH_SPACE;
		tab_end = '0;
		scroll  = 1'b0;
		case (ch)
			tte_pkg::CH_LF: begin
				nl = nl + RH1'(1);
				nc = '0;
			end
			tte_pkg::CH_CR: begin
				f_cnt = CW1'(cur_col_q);
				nc    = '0;
			end
			tte_pkg::CH_BS: begin
				if (nc != '0) begin
					nc = nc - CW1'(1);
				end
				sw_en = 1'b1;
				s_col = CW'(nc);
			end
			tte_pkg::CH_TAB: begin
				if (cur_col_q[2:0] != 3'd0) begin
					tab_end = (nc | CW1'(7)) + CW1'(1);
					if (tab_end > w) begin
						tab_end = w;
					end
					f_col = nc;
					f_cnt = tab_end - nc;
					nc    = tab_end;
				end
			end
			default: begin
				if (ch inside {[8'd32:8'd127]}) begin
					sw_en = 1'b1;
					s_dat = ch[6:0];
					nc    = nc + CW1'(1);
				end
			end
		endcase
		if (nc >= w) begin
			nc = '0;
			nl = nl + RH1'(1);
		end
		if (nl >= h) begin
			scroll = 1'b1;
			nl     = h - RH1'(1);
		end
	end

	// Store port selection; the states never overlap, the scroll write stage
	// drains in the cycle after the last scroll read.
	always_comb begin
		we    = 1'b0;
		waddr = cell_addr(8'(cur_row_q), 9'(s_col));
		wdata = s_dat;
		if (v_s1) begin
			we    = 1'b1;
			waddr = addr_s1;
			wdata = copy_s1 ? rdata : tte_pkg::CH_SPACE;
		end else if (state_q == ST_FILL) begin
			we    = 1'b1;
			waddr = fill_ptr_q;
			wdata = tte_pkg::CH_SPACE;
		end else if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = AW'(sc_q);
			wdata = tte_pkg::CH_SPACE;
		end else if (acc && is_ctl && sw_en) begin
			we = 1'b1;
		end
		if (state_q == ST_SCROLL) begin
			raddr = AW'(sc_q + SW'(MAX_COLS));
		end else begin
			raddr = cell_addr(8'(rrow), 9'(rcol));
		end
	end

	tte_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			columns_q     <= tte_pkg::COLS_RESET;
			rows_q        <= tte_pkg::ROWS_RESET;
			cur_row_q     <= '0;
			cur_col_q     <= '0;
			sc_q          <= '0;
			clr_to_out_q  <= 1'b0;
			fill_ptr_q    <= '0;
			fill_cnt_q    <= '0;
			scroll_pend_q <= 1'b0;
			scrolled_q    <= 1'b0;
			cleared_q     <= 1'b0;
			rd_ok_q       <= 1'b0;
			cell_q        <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			v_s1          <= 1'b0;
			copy_s1       <= 1'b0;
			addr_s1       <= '0;
		end else begin
			v_s1 <= (state_q == ST_SCROLL);
			if (m_tvalid_q && m_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			if (cfg_wr) begin
				if (paddr[2]) begin
					rows_q <= pwdata[6:0];
				end else begin
					columns_q <= pwdata[7:0];
				end
				cur_row_q <= '0;
				cur_col_q <= '0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (sc_q == SW'(DEPTH - 1)) begin
						sc_q    <= '0;
						state_q <= clr_to_out_q ? ST_OUT : ST_IDLE;
					end else begin
						sc_q <= sc_q + SW'(1);
					end
				end
				ST_IDLE: begin
					if (acc) begin
						scrolled_q <= 1'b0;
						cleared_q  <= 1'b0;
						cell_q     <= '0;
						if (mode) begin
							rd_ok_q <= (7'(rrow) < 7'(MAX_ROWS > 64 ? 64 : MAX_ROWS))
								&& (8'(rcol) < 8'(MAX_COLS > 128 ? 128 : MAX_COLS));
							state_q <= ST_RD;
						end else if (is_ff) begin
							cur_row_q    <= '0;
							cur_col_q    <= '0;
							cleared_q    <= 1'b1;
							clr_to_out_q <= 1'b1;
							sc_q         <= '0;
							state_q      <= ST_CLEAR;
						end else if (is_ctl) begin
							cur_row_q     <= RW'(nl);
							cur_col_q     <= CW'(nc);
							scrolled_q    <= scroll;
							scroll_pend_q <= scroll;
							fill_ptr_q    <= cell_addr(8'(cur_row_q), 9'(f_col));
							fill_cnt_q    <= f_cnt;
							sc_q          <= '0;
							if (f_cnt != '0) begin
								state_q <= ST_FILL;
							end else if (scroll) begin
								state_q <= ST_SCROLL;
							end else begin
								state_q <= ST_OUT;
							end
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_FILL: begin
					fill_ptr_q <= fill_ptr_q + AW'(1);
					fill_cnt_q <= fill_cnt_q - CW1'(1);
					if (fill_cnt_q == CW1'(1)) begin
						state_q <= scroll_pend_q ? ST_SCROLL : ST_OUT;
					end
				end
				ST_SCROLL: begin
					// Row copy: read one row ahead; the write-back address and copy flag are registered.
					addr_s1 <= AW'(sc_q);
					copy_s1 <= (sc_q < h_copy);
					if (sc_q == h_tot - SW'(1)) begin
						sc_q    <= '0;
						state_q <= ST_OUT;
					end else begin
						sc_q <= sc_q + SW'(1);
					end
				end
				ST_RD: begin
					cell_q  <= rd_ok_q ? rdata : 7'd0;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {1'b0, cell_q, cleared_q, scrolled_q,
							esc_stat.active, esc_stat.bg, esc_stat.fg,
							7'(cur_col_q), 6'(cur_row_q)};
						clr_to_out_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? {25'd0, rows_q} : {24'd0, columns_q};

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("item accepted during clearing pass");

	a_cursor_in_view: assert property (@(posedge clk) disable iff (!arst_n)
		(CW1'(cur_col_q) < w) && (RH1'(cur_row_q) < h))
		else $error("cursor outside the screen in use");

	a_scroll_write: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(state_q == ST_SCROLL))
		else $error("scroll write stage active outside a scroll");

endmodule

// ===== bench/tb_text_terminal_char_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the text terminal character engine
// Streams output bytes and cell reads into the engine under several screen
// sizes. A cycle-free model of the screen, the cursor, the palette and the
// escape parser predicts each result, and the results are compared in order.
// ----------------------------------------------------------------------------
module tb_text_terminal_char_engine_top;

	localparam bit MODE_PUT  = 1'b0;
	localparam bit MODE_READ = 1'b1;
	localparam int REG_COLUMNS = 0;
	localparam int REG_ROWS    = 1;
	localparam int STALL_LIMIT = 40000;
	localparam int NROWS = tte_pkg::MAX_ROWS_DEF;
	localparam int NCOLS = tte_pkg::MAX_COLS_DEF;

	typedef enum int {ESC_IDLE, ESC_OPEN, ESC_FIRST, ESC_SECOND} esc_phase_t;

	typedef struct {
		bit       mode;
		bit [7:0] ch;
		bit [5:0] rrow;
		bit [6:0] rcol;
	} term_item_t;

	typedef struct {
		bit [5:0] crow;
		bit [6:0] ccol;
		bit [3:0] fg;
		bit [3:0] bg;
		bit       esc;
		bit       scr;
		bit       clr;
		bit [6:0] cell_chr;
	} term_view_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;  // char_in[7:0], read_row[13:8], read_col[20:14]
	logic [0:0]  s_tuser = '0;  // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// cursor_row[5:0], cursor_col[12:6], fg_index[16:13], bg_index[20:17],
	// in_escape[21], scrolled[22], cleared[23], cell_char[30:24]
	logic [31:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	text_terminal_char_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	term_item_t pending_bytes[$];
	term_view_t expected_views[$];
	int errors = 0;
	int accepted = 0;
	bit quiet = 1'b0;
	bit busy_cfg = 1'b0;

	// Shadow of the engine.
	bit [6:0] screen[NROWS][NCOLS];
	int unsigned cur_r, cur_c, fg_cur, bg_cur, esc_len, esc_num, cfg_cols, cfg_rows;
	esc_phase_t esc_ph;

	function automatic void blank_screen();
		foreach (screen[r, c]) screen[r][c] = tte_pkg::CH_SPACE;
	endfunction

	function automatic void set_cell(int unsigned r, int unsigned c, bit [6:0] v);
		if (r < NROWS && c < NCOLS) screen[r][c] = v;
	endfunction

	function automatic void apply_colour(int unsigned n);
		if (n == tte_pkg::SGR_RESET) begin
			fg_cur = tte_pkg::FG_RESET;
			bg_cur = tte_pkg::BG_RESET;
		end else if (n >= tte_pkg::SGR_FG_LO && n <= tte_pkg::SGR_FG_HI)
			fg_cur = n - tte_pkg::SGR_FG_LO;
		else if (n == tte_pkg::SGR_FG_DEF) fg_cur = tte_pkg::FG_RESET;
		else if (n >= tte_pkg::SGR_BG_LO && n <= tte_pkg::SGR_BG_HI)
			bg_cur = n - tte_pkg::SGR_BG_LO;
		else if (n == tte_pkg::SGR_BG_DEF) bg_cur = tte_pkg::BG_RESET;
	endfunction

	function automatic void parse_escape(bit [7:0] c);
		bit done = 1'b0;
		bit digit = (c >= "0" && c <= "9");
		longint unsigned v;
		esc_len++;
		case (esc_ph)
			ESC_OPEN: begin
				if (c == tte_pkg::CH_LBRK) begin
					esc_ph = ESC_FIRST;
					esc_num = 0;
				end else done = 1'b1;
			end
			ESC_FIRST: begin
				if (digit) begin
					v = longint'(esc_num) * 10 + (c - "0");
					esc_num = (v > tte_pkg::NUM_SAT) ? tte_pkg::NUM_SAT : v;
				end else if (c == tte_pkg::CH_SEMI) esc_ph = ESC_SECOND;
				else begin
					if (c == tte_pkg::CH_SGR) apply_colour(esc_num);
					done = 1'b1;
				end
			end
			default: begin
				if (!digit) begin
					if (c == tte_pkg::CH_SGR) apply_colour(esc_num);
					done = 1'b1;
				end
			end
		endcase
		if (!done && esc_len >= tte_pkg::ESC_LIMIT_DEF) done = 1'b1;
		if (done) begin
			esc_len = 0;
			esc_ph = ESC_IDLE;
			esc_num = 0;
		end
	endfunction

	function automatic term_view_t emulate_item(term_item_t it);
		term_view_t o;
		int unsigned w, h, nl, nc;
		o = '{default: 0};
		w = (cfg_cols < 1) ? 1 : (cfg_cols > NCOLS ? NCOLS : cfg_cols);
		h = (cfg_rows < 1) ? 1 : (cfg_rows > NROWS ? NROWS : cfg_rows);
		if (it.mode == MODE_READ) begin
			o.cell_chr = screen[it.rrow][it.rcol];
		end else if (!it.ch[7]) begin
			if (esc_ph != ESC_IDLE) parse_escape(it.ch);
			else if (it.ch == tte_pkg::CH_ESC) begin
				esc_ph = ESC_OPEN;
				esc_len = 1;
				esc_num = 0;
			end else if (it.ch == tte_pkg::CH_FF) begin
				blank_screen();
				cur_r = 0;
				cur_c = 0;
				o.clr = 1'b1;
			end else begin
				nl = cur_r;
				nc = cur_c;
				if (it.ch == tte_pkg::CH_LF) begin
					nl++;
					nc = 0;
				end else if (it.ch == tte_pkg::CH_CR) begin
					while (nc > 0) begin
						nc--;
						set_cell(nl, nc, tte_pkg::CH_SPACE);
					end
				end else if (it.ch == tte_pkg::CH_BS) begin
					if (nc > 0) nc--;
					set_cell(nl, nc, tte_pkg::CH_SPACE);
				end else if (it.ch == tte_pkg::CH_TAB) begin
					while (nc % 8 != 0 && nc < w) begin
						set_cell(nl, nc, tte_pkg::CH_SPACE);
						nc++;
					end
				end else if (it.ch >= 32) begin
					set_cell(nl, nc, it.ch[6:0]);
					nc++;
				end
				if (nc >= w) begin
					nc = 0;
					nl++;
				end
				if (nl >= h) begin
					for (int r = 0; r + 1 < h; r++)
						for (int c = 0; c < NCOLS; c++) screen[r][c] = screen[r + 1][c];
					for (int c = 0; c < NCOLS; c++) screen[h - 1][c] = tte_pkg::CH_SPACE;
					nl--;
					o.scr = 1'b1;
				end
				if (nl >= h) nl = h - 1;
				cur_r = nl;
				cur_c = nc;
			end
		end
		o.crow = cur_r;
		o.ccol = cur_c;
		o.fg = fg_cur;
		o.bg = bg_cur;
		o.esc = (esc_ph != ESC_IDLE);
		return o;
	endfunction

	// Sender: one item on offer at a time, random gaps between items.
	int send_gap = 0;
	bit s_taken = 1'b0;
	always @(posedge clk) s_taken <= s_tvalid && s_tready;

	always @(negedge clk) begin
		term_item_t it;
		if (!s_tvalid || s_taken) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_tvalid <= 1'b0;
			end else if (pending_bytes.size() > 0 && !busy_cfg) begin
				it = pending_bytes.pop_front();
				s_tdata <= {3'b000, it.rcol, it.rrow, it.ch};
				s_tuser <= it.mode;
				s_tvalid <= 1'b1;
				if (!quiet && ((accepted / 64) % 3 != 0) && $urandom_range(0, 3) == 0)
					send_gap <= $urandom_range(1, 13);
			end else s_tvalid <= 1'b0;
		end
	end

	// Predict at the accepting edge.
	always @(posedge clk) begin
		term_item_t it;
		if (s_tvalid && s_tready) begin
			it.ch = s_tdata[7:0];
			it.rrow = s_tdata[13:8];
			it.rcol = s_tdata[20:14];
			it.mode = s_tuser[0];
			expected_views.push_back(emulate_item(it));
			accepted++;
		end
	end

	// Receiver: random stall bursts, plus one long hold-off.
	int ready_hold = 0;
	bit pressed = 1'b0;
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready <= 1'b0;
		end else if (!pressed && accepted >= 300) begin
			pressed <= 1'b1;
			ready_hold <= 400;
			m_tready <= 1'b0;
		end else if (!quiet && ((accepted / 80) % 3 != 1) && $urandom_range(0, 4) == 0) begin
			ready_hold <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else m_tready <= 1'b1;
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		term_view_t e;
		if (m_tvalid && m_tready) begin
			if (expected_views.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				errors++;
			end else begin
				e = expected_views.pop_front();
				check_field("cursor_row", e.crow, m_tdata[5:0]);
				check_field("cursor_col", e.ccol, m_tdata[12:6]);
				check_field("fg_index", e.fg, m_tdata[16:13]);
				check_field("bg_index", e.bg, m_tdata[20:17]);
				check_field("in_escape", e.esc, m_tdata[21]);
				check_field("scrolled", e.scr, m_tdata[22]);
				check_field("cleared", e.clr, m_tdata[23]);
				check_field("cell_char", e.cell_chr, m_tdata[30:24]);
			end
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_text_terminal_char_engine_top: errors");
			$finish;
		end else quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(int idx, bit [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 3'(4 * idx);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_COLUMNS) cfg_cols = value[7:0];
		else cfg_rows = value[6:0];
		cur_r = 0;
		cur_c = 0;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_bytes.size() > 0 || expected_views.size() > 0 || s_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_size(bit [31:0] cols, bit [31:0] rows);
		wait_idle();
		busy_cfg = 1'b1;
		write_reg(REG_COLUMNS, cols);
		write_reg(REG_ROWS, rows);
		busy_cfg = 1'b0;
	endtask

	task automatic add_byte(bit [7:0] b);
		term_item_t it;
		it.mode = MODE_PUT;
		it.ch = b;
		it.rrow = $urandom;
		it.rcol = $urandom;
		pending_bytes.push_back(it);
	endtask

	task automatic add_read(bit [5:0] r, bit [6:0] c);
		term_item_t it;
		it.mode = MODE_READ;
		it.ch = $urandom;
		it.rrow = r;
		it.rcol = c;
		pending_bytes.push_back(it);
	endtask

	task automatic add_text(string s);
		foreach (s[i]) add_byte(s[i]);
	endtask

	// Queues about n items; a sequence counts as the bytes it adds.
	task automatic add_random(int n);
		int k, made, before_n;
		bit [7:0] ctl[4];
		ctl = '{tte_pkg::CH_LF, tte_pkg::CH_CR, tte_pkg::CH_BS, tte_pkg::CH_TAB};
		made = 0;
		while (made < n) begin
			before_n = pending_bytes.size();
			k = $urandom_range(0, 99);
			if (k < 50) add_byte($urandom_range(32, 127));
			else if (k < 62) add_byte(ctl[$urandom_range(0, 3)]);
			else if (k < 65) add_byte($urandom_range(0, 31));
			else if (k < 68) add_byte($urandom_range(128, 255));
			else if (k < 69) add_byte(tte_pkg::CH_FF);
			else if (k < 80) add_read($urandom, $urandom);
			else if (k < 92) begin
				// colour sequence, sometimes with a stray final byte
				add_byte(tte_pkg::CH_ESC);
				add_byte(tte_pkg::CH_LBRK);
				case ($urandom_range(0, 3))
					0: add_text($sformatf("%0d", $urandom_range(30, 49)));
					1: add_text($sformatf("%0d;%0d", $urandom_range(0, 49), $urandom_range(0, 9)));
					2: add_text($sformatf("%0d", $urandom_range(0, 99999)));
					default: ;
				endcase
				add_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(32, 127))
					: tte_pkg::CH_SGR);
			end else begin
				// broken or overlong sequence
				add_byte(tte_pkg::CH_ESC);
				if ($urandom_range(0, 1)) add_byte(tte_pkg::CH_LBRK);
				repeat ($urandom_range(0, 12)) add_byte($urandom_range(0, 127));
			end
			made += pending_bytes.size() - before_n;
		end
	endtask

	initial begin
		blank_screen();
		cur_r = 0;
		cur_c = 0;
		fg_cur = tte_pkg::FG_RESET;
		bg_cur = tte_pkg::BG_RESET;
		esc_ph = ESC_IDLE;
		esc_len = 0;
		esc_num = 0;
		cfg_cols = tte_pkg::COLS_RESET;
		cfg_rows = tte_pkg::ROWS_RESET;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset size.
		add_byte(tte_pkg::CH_BS);
		add_text("A~ ");
		add_byte(8'd127);
		add_byte(tte_pkg::CH_BS);
		add_byte(tte_pkg::CH_TAB);
		add_byte(tte_pkg::CH_CR);
		add_byte(tte_pkg::CH_LF);
		add_byte(8'd0);
		add_byte(8'd31);
		add_byte(8'd200);
		add_byte(8'd255);
		add_text("\033[31m\033[45;1m\033[39m\033[49m\033[0m\033X");
		add_text("\033[999999999");
		add_read(0, 1);
		add_read(63, 127);
		add_byte(tte_pkg::CH_FF);

		set_size(16, 4);
		add_random(400);
		set_size(1, 1);
		add_random(150);
		set_size(0, 0);
		add_random(100);
		set_size(128, 64);
		add_random(150);
		set_size(255, 127);
		add_random(100);
		set_size(8, 2);
		add_random(400);
		set_size(40, 3);
		quiet = 1'b1;
		add_random(330);

		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) $display("tb_text_terminal_char_engine_top: clean");
		else $display("tb_text_terminal_char_engine_top: errors");
		$finish;
	end

endmodule
